@@ design/pfa_pkg.sv @@
// shared types and constants of the partition fit allocator
`default_nettype none

package pfa_pkg;

	// fixed field widths of the channel words
	localparam int unsigned CMD_W        = 1;
	localparam int unsigned BLK_IDX_W    = 4;
	localparam int unsigned REQ_SIZE_W   = 16;
	localparam int unsigned STATUS_W     = 2;
	localparam int unsigned CAP_LEFT_W   = 16;

	// configuration port
	localparam int unsigned CFG_IDX_W    = 1;
	localparam int unsigned CFG_DATA_W   = 5;
	localparam int unsigned FIT_MODE_W   = 2;
	localparam int unsigned BLK_IN_USE_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIT_MODE      = 1'b0,
		REG_BLOCKS_IN_USE = 1'b1
	} cfg_reg_t;

	typedef enum logic [FIT_MODE_W-1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} fit_mode_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 1'b0,
		CMD_REQUEST = 1'b1
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_LOADED        = 2'd0,
		ST_ALLOCATED     = 2'd1,
		ST_NOT_ALLOCATED = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

endpackage

`default_nettype wire

@@ design/pfa_req_if.sv @@
// input channel: load or request word
`default_nettype none

interface pfa_req_if
	import pfa_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      command;
	logic [BLK_IDX_W-1:0]  block_index;
	logic [REQ_SIZE_W-1:0] request_size;

	modport source (output valid, output command, output block_index,
		output request_size, input ready);
	modport sink (input valid, input command, input block_index,
		input request_size, output ready);
endinterface

`default_nettype wire

@@ design/pfa_rsp_if.sv @@
// result channel: status, granted block and capacity left
`default_nettype none

interface pfa_rsp_if
	import pfa_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [STATUS_W-1:0]   status;
	logic [BLK_IDX_W-1:0]  granted_block;
	logic [CAP_LEFT_W-1:0] capacity_left;

	modport source (output valid, output status, output granted_block,
		output capacity_left, input ready);
	modport sink (input valid, input status, input granted_block,
		input capacity_left, output ready);
endinterface

`default_nettype wire

@@ design/pfa_cfg_if.sv @@
// configuration write channel
`default_nettype none

interface pfa_cfg_if
	import pfa_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ design/pfa_cap_store.sv @@
// capacity memory with one read and one write port and a clearing sweep after reset
`default_nettype none

module pfa_cap_store
	import pfa_pkg::*;
#(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic                     busy
);
	localparam int unsigned AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;
	logic [AW-1:0]    clr_addr_q;
	logic             busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			if (32'(clr_addr_q) == DEPTH - 1) begin
				busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

`default_nettype wire

@@ design/partition_fit_allocator_unit.sv @@
// Partition fit allocator: keeps a remaining capacity per block in a memory with one
// read and one write port and grants requests by first, best, worst or next fit. A
// request word searches n entries, where n is blocks_in_use saturated to NUM_BLOCKS:
// the capacity memory is read one entry per cycle over its read port, then the
// reduced capacity is written back. After reset the memory is swept to zero, and no
// word is accepted during the sweep; configuration writes are taken at any time. A
// result waits in an output register until taken; the next word may be accepted
// meanwhile, but its own result is held back until the earlier one has gone.
`default_nettype none

module partition_fit_allocator_unit
	import pfa_pkg::*;
#(
	parameter int unsigned NUM_BLOCKS = 16,
	parameter int unsigned SIZE_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	pfa_req_if.sink    req,
	pfa_rsp_if.source  rsp,
	pfa_cfg_if.sink    cfg
);
	localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
	localparam int unsigned CNT_W = $clog2(NUM_BLOCKS + 1);

	state_t                  state_q;
	fit_mode_t               fit_mode_q;
	logic [BLK_IN_USE_W-1:0] blocks_q;
	logic [IDX_W-1:0]        ptr_q;

	cmd_t                    cmd_q;
	logic [SIZE_WIDTH-1:0]   size_q;
	logic [BLK_IDX_W-1:0]    load_idx_q;
	logic                    load_ok_q;
	logic [CNT_W-1:0]        n_q;
	logic [CNT_W-1:0]        issued_q;
	logic [IDX_W-1:0]        addr_q;
	logic                    found_q;
	logic [IDX_W-1:0]        best_idx_q;
	logic [SIZE_WIDTH-1:0]   best_cap_q;
	logic                    rd_valid_s1;
	logic [IDX_W-1:0]        rd_addr_s1;

	logic                    out_valid_q;
	status_t                 status_q;
	logic [BLK_IDX_W-1:0]    block_q;
	logic [CAP_LEFT_W-1:0]   cap_left_q;

	logic                    clearing;
	logic                    in_take;
	logic                    fin_go;
	logic [CNT_W-1:0]        n_c;
	logic [IDX_W-1:0]        start_c;
	logic                    rd_en;
	logic [SIZE_WIDTH-1:0]   rd_data;
	logic                    fits;
	logic                    take;
	logic                    wr_en;
	logic [IDX_W-1:0]        wr_addr;
	logic [SIZE_WIDTH-1:0]   wr_data;
	logic [SIZE_WIDTH-1:0]   reduced;

	pfa_cap_store #(
		.DEPTH (NUM_BLOCKS),
		.WIDTH (SIZE_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.busy    (clearing)
	);

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= FIT_FIRST;
			blocks_q   <= BLK_IN_USE_W'(16);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FIT_MODE:      fit_mode_q <= fit_mode_t'(cfg.data[FIT_MODE_W-1:0]);
				REG_BLOCKS_IN_USE: blocks_q <= cfg.data[BLK_IN_USE_W-1:0];
				default:           ;
			endcase
		end
	end

	// searched entries, saturated to the table size
	always_comb begin
		if (32'(blocks_q) > NUM_BLOCKS) begin
			n_c = CNT_W'(NUM_BLOCKS);
		end else begin
			n_c = CNT_W'(blocks_q);
		end
		if (fit_mode_q == FIT_NEXT && 32'(ptr_q) < 32'(n_c)) begin
			start_c = ptr_q;
		end else begin
			start_c = '0;
		end
	end

	assign req.ready = (state_q == S_IDLE) && !clearing;
	assign in_take   = req.valid && req.ready;
	assign fin_go    = (state_q == S_FIN) && (!out_valid_q || rsp.ready);
	assign rd_en     = (state_q == S_SCAN) && (issued_q != n_q);

	// scan compare on the word read last cycle
	assign fits = rd_data >= size_q;
	always_comb begin
		take = 1'b0;
		if (rd_valid_s1 && fits) begin
			case (fit_mode_q)
				FIT_BEST:  take = !found_q || (rd_data < best_cap_q);
				FIT_WORST: take = !found_q || (rd_data > best_cap_q);
				default:   take = !found_q;
			endcase
		end
	end

	// write back: loaded capacity or reduced capacity of the chosen block
	assign reduced = best_cap_q - size_q;
	always_comb begin
		if (cmd_q == CMD_LOAD) begin
			wr_en   = fin_go && load_ok_q;
			wr_addr = IDX_W'(load_idx_q);
			wr_data = size_q;
		end else begin
			wr_en   = fin_go && found_q;
			wr_addr = best_idx_q;
			wr_data = reduced;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			found_q     <= 1'b0;
			issued_q    <= '0;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (fin_go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						found_q  <= 1'b0;
						issued_q <= '0;
						if (cmd_t'(req.command) == CMD_LOAD) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						issued_q <= issued_q + CNT_W'(1);
					end else begin
						state_q <= S_FIN;
					end
					if (take) begin
						found_q <= 1'b1;
					end
				end
				S_FIN: begin
					if (fin_go) begin
						state_q <= S_IDLE;
						if (cmd_q == CMD_REQUEST && found_q && fit_mode_q == FIT_NEXT) begin
							ptr_q <= best_idx_q;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			cmd_q      <= cmd_t'(req.command);
			size_q     <= SIZE_WIDTH'(req.request_size);
			load_idx_q <= req.block_index;
			load_ok_q  <= 32'(req.block_index) < NUM_BLOCKS;
			n_q        <= n_c;
			addr_q     <= start_c;
		end else if (rd_en) begin
			if (32'(addr_q) + 32'd1 == 32'(n_q)) begin
				addr_q <= '0;
			end else begin
				addr_q <= addr_q + IDX_W'(1);
			end
		end
		rd_addr_s1 <= addr_q;
		if (take) begin
			best_idx_q <= rd_addr_s1;
			best_cap_q <= rd_data;
		end
		if (fin_go) begin
			if (cmd_q == CMD_LOAD) begin
				status_q   <= ST_LOADED;
				block_q    <= load_idx_q;
				cap_left_q <= load_ok_q ? CAP_LEFT_W'(size_q) : '0;
			end else if (found_q) begin
				status_q   <= ST_ALLOCATED;
				block_q    <= BLK_IDX_W'(best_idx_q);
				cap_left_q <= CAP_LEFT_W'(reduced);
			end else begin
				status_q   <= ST_NOT_ALLOCATED;
				block_q    <= '0;
				cap_left_q <= '0;
			end
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.granted_block = block_q;
	assign rsp.capacity_left = cap_left_q;

	// the capacity memory is never read and written in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n) !(rd_en && wr_en))
		else $error("capacity memory read and write overlap");

	// the scan never issues more reads than entries searched
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (issued_q <= n_q))
		else $error("scan ran past the searched entries");

	// a granted block lies within the searched entries
	assert property (@(posedge clk) disable iff (!arst_n)
		(fin_go && cmd_q == CMD_REQUEST && found_q) |-> (32'(best_idx_q) < 32'(n_q)))
		else $error("granted block outside searched range");

	// a compare result arrives only the cycle after a read was issued
	assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> $past(rd_en))
		else $error("read data flagged without a read");

endmodule

`default_nettype wire
